@@ rtl/swfr_pkg.sv @@
package swfr_pkg;

  localparam int FRAME_BYTES   = 92;
  localparam int CRC_SPAN      = 90;
  localparam int PAYLOAD_WORDS = 21;
  localparam int ROWS          = (FRAME_BYTES + 3) / 4;
  localparam int CNT_W         = $clog2(FRAME_BYTES + 1);
  localparam int ROW_W         = $clog2(ROWS);
  localparam int IDX_W         = 5;

  localparam logic [31:0] SYNC_WORD = 32'h8080_8080;
  localparam logic [31:0] SYNC_IDLE = 32'h7F7F_7F7F;
  localparam logic [7:0]  SYNC_BYTE = 8'h80;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_CRC     = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_POLY    = 2'd1;
  localparam logic [1:0] CFG_INIT    = 2'd2;

  localparam logic [15:0] TIMEOUT_RST = 16'd3000;
  localparam logic [7:0]  POLY_RST    = 8'h07;
  localparam logic [7:0]  INIT_RST    = 8'h00;

  typedef struct packed {
    logic accept;
    logic sync_step;
    logic load_err;
    logic load_word;
  } swfr_cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic evt_err;
    logic frame_good;
    logic sync_last;
    logic slot_free;
    logic word_last;
  } swfr_sts_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ rtl/sync_word_frame_receiver.sv @@
// Channel  Signals                                         Direction
// in       in_valid/in_ready, in_opcode, in_rx_byte        input transaction
// out      out_valid/out_ready, out_status, out_word_index, result transaction
//          out_word_value, out_good_count, out_error_count,
//          out_last
// cfg      cfg_we, cfg_index, cfg_wdata                    register write
//
// Idle accepts every byte or tick; a sync hit then runs the CRC over the four sync bytes.
// A good frame emits 21 words from the frame word memory after a read prime state, one
// per cycle while the output register is free; error results load once it is free.
// Synchronous active-low reset; the frame memory is not cleared.
// Out stalls hold the block only while a result is pending; other inputs keep flowing.
module sync_word_frame_receiver
  import swfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [4:0]  out_word_index,
  output logic [31:0] out_word_value,
  output logic [31:0] out_good_count,
  output logic [31:0] out_error_count,
  output logic        out_last
);

  swfr_cmd_t cmd;
  swfr_sts_t sts;

  swfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swfr_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_opcode       (in_opcode),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_word_index  (out_word_index),
    .out_word_value  (out_word_value),
    .out_good_count  (out_good_count),
    .out_error_count (out_error_count),
    .out_last        (out_last),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

@@ rtl/swfr_ctrl.sv @@
module swfr_ctrl
  import swfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  swfr_sts_t sts,
  output swfr_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SYNC = 3'd1;
  localparam logic [2:0] S_ERR  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_WORD = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          if (sts.sync_hit) state_nxt = S_SYNC;
          else if (sts.evt_err) state_nxt = S_ERR;
          else if (sts.frame_good) state_nxt = S_READ;
        end
      end
      S_SYNC: begin
        cmd.sync_step = 1'b1;
        if (sts.sync_last) state_nxt = S_IDLE;
      end
      S_ERR: begin
        if (sts.slot_free) begin
          cmd.load_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_WORD;
      end
      S_WORD: begin
        if (sts.slot_free) begin
          cmd.load_word = 1'b1;
          if (sts.word_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

@@ rtl/swfr_dpath.sv @@
module swfr_dpath
  import swfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_opcode,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [4:0]  out_word_index,
  output logic [31:0] out_word_value,
  output logic [31:0] out_good_count,
  output logic [31:0] out_error_count,
  output logic        out_last,
  input  swfr_cmd_t   cmd,
  output swfr_sts_t   sts
);

  logic [15:0]      timeout_r;
  logic [7:0]       poly_r;
  logic [7:0]       init_r;
  logic [31:0]      sync_r;
  logic             recv_r;
  logic [CNT_W-1:0] cnt_r;
  logic [7:0]       crc_r;
  logic [7:0]       chk_lo_r;
  logic [31:0]      asm_r;
  logic [31:0]      good_r;
  logic [31:0]      err_r;
  logic [15:0]      ms_r;
  logic [1:0]       err_code_r;
  logic [IDX_W-1:0] k_r;
  logic [31:0]      rd_r;
  logic             out_valid_r;
  logic [31:0]      mem [ROWS];

  logic             is_tick;
  logic [15:0]      ms_inc;
  logic             tmo;
  logic [31:0]      shift_nxt;
  logic             hit;
  logic             final_byte;
  logic             crc_ok;
  logic [31:0]      asm_nxt;
  logic             wr_en;
  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] rd_row;
  logic [7:0]       crc_byte;

  assign is_tick    = (in_opcode == OP_TICK);
  assign ms_inc     = (ms_r != 16'hFFFF) ? ms_r + 16'd1 : ms_r;
  assign tmo        = is_tick && (ms_inc >= timeout_r);
  assign shift_nxt  = {sync_r[23:0], in_rx_byte};
  assign hit        = !is_tick && !recv_r && (shift_nxt == SYNC_WORD);
  assign final_byte = !is_tick && recv_r && (cnt_r == CNT_W'(FRAME_BYTES - 1));
  assign crc_ok     = (crc_r == chk_lo_r) && (in_rx_byte == 8'h00);
  assign asm_nxt    = {in_rx_byte, asm_r[31:8]};
  assign wr_en      = cmd.accept && !is_tick && recv_r && (cnt_r[1:0] == 2'b11);
  assign wr_row     = cnt_r[CNT_W-1:2];
  assign rd_row     = ROW_W'(k_r) + ROW_W'(1) + ROW_W'(cmd.load_word);
  assign crc_byte   = crc8_byte(crc_r, cmd.sync_step ? SYNC_BYTE : in_rx_byte, poly_r);

  assign sts.sync_hit   = hit;
  assign sts.evt_err    = tmo || (final_byte && !crc_ok);
  assign sts.frame_good = final_byte && crc_ok;
  assign sts.sync_last  = (cnt_r[1:0] == 2'b11);
  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.word_last  = (k_r == IDX_W'(PAYLOAD_WORDS - 1));

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      poly_r      <= POLY_RST;
      init_r      <= INIT_RST;
      sync_r      <= SYNC_IDLE;
      recv_r      <= 1'b0;
      cnt_r       <= '0;
      crc_r       <= INIT_RST;
      good_r      <= '0;
      err_r       <= '0;
      ms_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout_r <= cfg_wdata;
          CFG_POLY:    poly_r    <= cfg_wdata[7:0];
          CFG_INIT:    init_r    <= cfg_wdata[7:0];
          default: ;
        endcase
      end

      if (cmd.accept) begin
        if (is_tick) begin
          ms_r <= tmo ? 16'd0 : ms_inc;
          if (tmo) begin
            recv_r <= 1'b0;
            err_r  <= err_r + 32'd1;
          end
        end else if (!recv_r) begin
          sync_r <= hit ? SYNC_IDLE : shift_nxt;
          if (hit) begin
            recv_r <= 1'b1;
            cnt_r  <= '0;
            crc_r  <= init_r;
          end
        end else begin
          if (cnt_r < CNT_W'(CRC_SPAN)) crc_r <= crc_byte;
          cnt_r <= cnt_r + CNT_W'(1);
          if (final_byte) begin
            recv_r <= 1'b0;
            if (crc_ok) begin
              good_r <= good_r + 32'd1;
              ms_r   <= '0;
              k_r    <= '0;
            end else begin
              err_r <= err_r + 32'd1;
            end
          end
        end
      end

      if (cmd.sync_step) begin
        crc_r <= crc_byte;
        cnt_r <= cnt_r + CNT_W'(1);
      end

      if (cmd.load_word) k_r <= k_r + IDX_W'(1);

      if (cmd.load_err || cmd.load_word) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !is_tick && recv_r) begin
      asm_r <= asm_nxt;
      if (cnt_r == CNT_W'(CRC_SPAN)) chk_lo_r <= in_rx_byte;
    end
    if (cmd.accept) begin
      if (tmo) err_code_r <= ST_TIMEOUT;
      else err_code_r <= ST_CRC;
    end
    if (cmd.load_err) begin
      out_status      <= err_code_r;
      out_word_index  <= '0;
      out_word_value  <= '0;
      out_good_count  <= good_r;
      out_error_count <= err_r;
      out_last        <= 1'b1;
    end else if (cmd.load_word) begin
      out_status      <= ST_GOOD;
      out_word_index  <= k_r;
      out_word_value  <= rd_r;
      out_good_count  <= good_r;
      out_error_count <= err_r;
      out_last        <= sts.word_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_row] <= asm_nxt;
    rd_r <= mem[rd_row];
  end

endmodule

@@ rtl/swfr_checker.sv @@
module swfr_checker
  import swfr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [4:0]  out_word_index,
  input logic [31:0] out_word_value,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word_value))
    else $error("out transaction changed while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_GOOD |-> out_last)
    else $error("error result without last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_GOOD |-> out_word_index == '0 && out_word_value == '0)
    else $error("error result carries payload");

  a_word_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_GOOD |->
      (out_last == (out_word_index == 5'(PAYLOAD_WORDS - 1))))
    else $error("last flag does not match final word");

endmodule

bind sync_word_frame_receiver swfr_checker u_swfr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_word_index (out_word_index),
  .out_word_value (out_word_value),
  .out_last       (out_last)
);

@@ tb/frame_result_checker.sv @@
module frame_result_checker
  import swfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [4:0]  out_word_index,
  input  logic [31:0] out_word_value,
  input  logic [31:0] out_good_count,
  input  logic [31:0] out_error_count,
  input  logic        out_last,
  output int          mismatches,
  output int          outstanding,
  output int          checked_results,
  output int          frames_good,
  output int          frames_crc,
  output int          timeouts
);

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  word_idx;
    logic [31:0] value;
    logic [31:0] good;
    logic [31:0] errs;
    logic        last;
  } frame_result_t;

  frame_result_t expected_words[$];
  frame_result_t want;

  logic [15:0] tmo_ms;
  logic [7:0]  crc_poly;
  logic [7:0]  crc_init;

  logic [31:0] hunt;
  logic        in_frame;
  int          fill;
  logic [7:0]  frame_bytes [0:FRAME_BYTES-1];
  logic [7:0]  crc;
  logic [31:0] good_total;
  logic [31:0] crc_total;
  logic [31:0] tmo_total;
  logic [15:0] ms_idle;

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    checked_results = 0;
    frames_good     = 0;
    frames_crc      = 0;
    timeouts        = 0;
  end

  function automatic logic [7:0] crc_shift_in(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    repeat (8) r = r[7] ? ((r << 1) ^ crc_poly) : (r << 1);
    return r;
  endfunction

  function automatic void queue_result(input logic [1:0] status, input logic [4:0] idx,
                                       input logic [31:0] value, input logic last);
    frame_result_t r;
    r.status   = status;
    r.word_idx = idx;
    r.value    = value;
    r.good     = good_total;
    r.errs     = crc_total + tmo_total;
    r.last     = last;
    expected_words.push_back(r);
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    if (fill < FRAME_BYTES) begin
      frame_bytes[fill] = b;
      if (fill < CRC_SPAN) crc = crc_shift_in(crc, b);
      fill++;
    end
  endfunction

  task automatic receive_event(input logic op, input logic [7:0] b);
    logic [15:0] check;
    logic [31:0] w;
    if (op == OP_TICK) begin
      if (ms_idle != 16'hFFFF) ms_idle++;
      if (ms_idle >= tmo_ms) begin
        ms_idle  = '0;
        in_frame = 1'b0;
        tmo_total++;
        timeouts++;
        queue_result(ST_TIMEOUT, '0, '0, 1'b1);
      end
    end else if (!in_frame) begin
      hunt = {hunt[23:0], b};
      if (hunt == SYNC_WORD) begin
        in_frame = 1'b1;
        fill     = 0;
        crc      = crc_init;
        repeat (4) take_byte(SYNC_BYTE);
        hunt = SYNC_IDLE;
      end
    end else begin
      take_byte(b);
      if (fill == FRAME_BYTES) begin
        in_frame = 1'b0;
        check = {frame_bytes[91], frame_bytes[90]};
        if ({8'h00, crc} != check) begin
          crc_total++;
          frames_crc++;
          queue_result(ST_CRC, '0, '0, 1'b1);
        end else begin
          good_total++;
          frames_good++;
          ms_idle = '0;
          for (int k = 0; k < PAYLOAD_WORDS; k++) begin
            w = {frame_bytes[4*k+7], frame_bytes[4*k+6], frame_bytes[4*k+5],
                 frame_bytes[4*k+4]};
            queue_result(ST_GOOD, k[4:0], w, k == PAYLOAD_WORDS - 1);
          end
        end
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tmo_ms     = TIMEOUT_RST;
      crc_poly   = POLY_RST;
      crc_init   = INIT_RST;
      hunt       = SYNC_IDLE;
      in_frame   = 1'b0;
      fill       = 0;
      crc        = INIT_RST;
      good_total = '0;
      crc_total  = '0;
      tmo_total  = '0;
      ms_idle    = '0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT: tmo_ms = cfg_wdata;
          CFG_POLY:    crc_poly = cfg_wdata[7:0];
          CFG_INIT:    crc_init = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) receive_event(in_opcode, in_rx_byte);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result transaction with nothing expected: status %0d index %0d",
                 out_status, out_word_index);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("word_index", 32'(want.word_idx), 32'(out_word_index));
          check_field("word_value", want.value, out_word_value);
          check_field("good_count", want.good, out_good_count);
          check_field("error_count", want.errs, out_error_count);
          check_field("last", 32'(want.last), 32'(out_last));
          checked_results++;
        end
      end
    end
    outstanding <= expected_words.size();
  end

endmodule

@@ tb/tb_sync_word_frame_receiver.sv @@
module tb_sync_word_frame_receiver;
  import swfr_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 30;

  typedef enum {SHAPE_GOOD, SHAPE_BAD_LOW, SHAPE_BAD_HIGH, SHAPE_CUT} frame_shape_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [4:0]  out_word_index;
  logic [31:0] out_word_value;
  logic [31:0] out_good_count;
  logic [31:0] out_error_count;
  logic        out_last;

  int mismatches;
  int outstanding;
  int checked_results;
  int frames_good;
  int frames_crc;
  int timeouts;

  int         n_sent;
  int         cycle_cnt;
  bit         calm;
  bit         hold_req;
  logic [7:0] cur_poly;
  logic [7:0] cur_init;

  sync_word_frame_receiver i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_word_index (out_word_index),
    .out_word_value (out_word_value),
    .out_good_count (out_good_count),
    .out_error_count(out_error_count),
    .out_last       (out_last)
  );

  frame_result_checker i_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_word_index (out_word_index),
    .out_word_value (out_word_value),
    .out_good_count (out_good_count),
    .out_error_count(out_error_count),
    .out_last       (out_last),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .checked_results(checked_results),
    .frames_good    (frames_good),
    .frames_crc     (frames_crc),
    .timeouts       (timeouts)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random backpressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 16);
    end
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // upper byte of the 8-bit registers carries junk to check masking
  task automatic set_config(input logic [15:0] tmo, input logic [7:0] poly,
                            input logic [7:0] init);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_index <= CFG_POLY;
    cfg_wdata <= {8'($urandom), poly};
    @(posedge clk);
    cfg_index <= CFG_INIT;
    cfg_wdata <= {8'($urandom), init};
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_poly = poly;
    cur_init = init;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(OP_TICK, 8'($urandom));
  endtask

  task automatic send_noise(input int count);
    logic [7:0] b;
    for (int n = 0; n < count; n++) begin
      b = ($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom);
      if (n == count - 1 && b == SYNC_BYTE) b = 8'h7F;
      send_item(OP_BYTE, b);
    end
  endtask

  task automatic send_frame(input frame_shape_t shape, input bit ticks_inside);
    logic [7:0] body [0:FRAME_BYTES-1];
    logic [7:0] crc;
    int pattern;
    int cut;
    pattern = $urandom_range(0, 3);
    cut = (shape == SHAPE_CUT) ? $urandom_range(4, 60) : FRAME_BYTES;
    crc = cur_init;
    for (int n = 0; n < CRC_SPAN; n++) begin
      if (n < 4) body[n] = SYNC_BYTE;
      else begin
        case (pattern)
          1: body[n] = 8'hFF;
          2: body[n] = 8'h00;
          default: body[n] = 8'($urandom);
        endcase
      end
      crc = crc8_byte(crc, body[n], cur_poly);
    end
    body[90] = crc;
    body[91] = 8'h00;
    if (shape == SHAPE_BAD_LOW) body[90] = crc ^ 8'($urandom_range(1, 255));
    if (shape == SHAPE_BAD_HIGH) body[91] = 8'($urandom_range(1, 255));
    for (int n = 0; n < cut; n++) begin
      if (ticks_inside && $urandom_range(0, 24) == 0) send_item(OP_TICK, 8'($urandom));
      send_item(OP_BYTE, body[n]);
    end
  endtask

  task automatic run_phase(input int target);
    int start;
    int pick;
    start = n_sent;
    do begin
      pick = $urandom_range(0, 99);
      if (pick < 55) send_frame(SHAPE_GOOD, $urandom_range(0, 3) == 0);
      else if (pick < 65) send_frame(SHAPE_BAD_LOW, 1'b0);
      else if (pick < 72) send_frame(SHAPE_BAD_HIGH, 1'b0);
      else if (pick < 78) send_frame(SHAPE_CUT, 1'b0);
      else if (pick < 90) send_noise($urandom_range(1, 8));
      else send_ticks($urandom_range(1, 5));
    end while (n_sent - start < target);
  endtask

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_TIMEOUT;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_opcode  = OP_BYTE;
    in_rx_byte = '0;
    n_sent     = 0;
    cycle_cnt  = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    cur_poly   = POLY_RST;
    cur_init   = INIT_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // start-up ticks, near-miss sync, sync split by a tick
    send_item(OP_TICK, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, SYNC_BYTE);
    send_item(OP_BYTE, SYNC_BYTE);
    send_item(OP_BYTE, SYNC_BYTE);
    send_item(OP_BYTE, 8'h7F);
    send_item(OP_BYTE, SYNC_BYTE);
    send_item(OP_BYTE, SYNC_BYTE);
    send_item(OP_BYTE, SYNC_BYTE);
    send_item(OP_TICK, 8'h55);
    send_item(OP_BYTE, SYNC_BYTE);
    send_item(OP_BYTE, 8'h12);
    send_item(OP_BYTE, 8'h34);
    drain();

    // timeout drops the frame in progress, then a plain timeout
    set_config(16'd2, POLY_RST, INIT_RST);
    send_item(OP_TICK, 8'hAA);
    send_item(OP_TICK, 8'h01);
    send_item(OP_TICK, 8'hFE);
    send_item(OP_BYTE, SYNC_BYTE);
    drain();

    set_config(16'hFFFF, 8'hFF, 8'hFF);
    run_phase(PHASE_ITEMS);
    drain();

    set_config(16'd1, 8'h00, 8'h00);
    run_phase(PHASE_ITEMS);
    drain();

    calm = 1'b1;
    set_config(16'($urandom_range(5, 40)), 8'($urandom), 8'($urandom));
    run_phase(PHASE_ITEMS);
    calm = 1'b0;
    drain();

    set_config(TIMEOUT_RST, POLY_RST, INIT_RST);
    hold_req = 1'b1;
    send_frame(SHAPE_GOOD, 1'b0);
    send_noise(8);
    drain();

    set_config(16'($urandom_range(100, 60000)), 8'($urandom), 8'($urandom));
    run_phase(PHASE_ITEMS);
    drain();

    $display("Sent %0d input transactions over seven register settings, incl. a long stall.",
             n_sent);
    $display("Checked %0d results: %0d good frames, %0d crc errors, %0d timeouts.",
             checked_results, frames_good, frames_crc, timeouts);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
